// ----- rtl/crip_pkg.sv -----
// Shared constants, types and helpers for the color ramp interpolator.
`timescale 1ns / 1ps
package crip_pkg;

	localparam int MAX_MARKERS = 8;
	localparam int IDX_W = $clog2(MAX_MARKERS);
	localparam int CNT_W = 4;
	localparam int VAL_W = 16;
	localparam int DIV_STEPS = VAL_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [1:0] FUNC_WR_COLOR = 2'd0;
	localparam logic [1:0] FUNC_WR_ALPHA = 2'd1;
	localparam logic [1:0] FUNC_SAMPLE = 2'd2;

	localparam logic REG_COLOR_COUNT = 1'b0;
	localparam logic REG_ALPHA_COUNT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST_RD,
		S_FIRST_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic mul;
		logic load;
		logic step;
	} lane_cmd_t;

	typedef struct packed {
		logic wr_color;
		logic wr_alpha;
		logic capture;
		logic first_rd;
		logic first_chk;
		logic scan_chk;
		logic [IDX_W-1:0] scan_idx;
		lane_cmd_t lane;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic all_done;
	} dp_sts_t;

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
		return (cnt > CNT_W'(MAX_MARKERS)) ? CNT_W'(MAX_MARKERS) : cnt;
	endfunction

endpackage

// ----- rtl/crip_lane.sv -----
// One channel lane: weighted sum of two markers and a restoring divider.
`timescale 1ns / 1ps
module crip_lane import crip_pkg::*; (
	input  logic             clk,
	input  lane_cmd_t        cmd,
	input  logic [VAL_W-1:0] va,
	input  logic [VAL_W-1:0] vb,
	input  logic [VAL_W-1:0] span,
	input  logic [VAL_W-1:0] delta,
	input  logic             interp,
	output logic [VAL_W-1:0] result
);

	logic [VAL_W-1:0]   rest;
	logic [2*VAL_W-1:0] prod_a_q;
	logic [2*VAL_W-1:0] prod_b_q;
	logic [2*VAL_W-1:0] num;
	logic [VAL_W-1:0]   rem_q;
	logic [VAL_W-1:0]   quo_q;
	logic [VAL_W:0]     trial;
	logic [VAL_W:0]     diff;
	logic               ge;

	assign rest  = span - delta;
	assign num   = prod_a_q + prod_b_q;
	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign ge    = trial >= {1'b0, span};
	assign diff  = trial - {1'b0, span};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_a_q <= (2*VAL_W)'(va) * (2*VAL_W)'(rest);
			prod_b_q <= (2*VAL_W)'(vb) * (2*VAL_W)'(delta);
		end
		if (cmd.load) begin
			rem_q <= num[2*VAL_W-1:VAL_W];
			quo_q <= num[VAL_W-1:0];
		end else if (cmd.step) begin
			rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign result = (interp && (span != '0)) ? quo_q : va;

endmodule

// ----- rtl/crip_datapath.sv -----
// Marker tables, segment search for both tracks, channel lanes and result registers.
`timescale 1ns / 1ps
module crip_datapath import crip_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [IDX_W-1:0] marker_index,
	input  logic [VAL_W-1:0] position,
	input  logic [VAL_W-1:0] red,
	input  logic [VAL_W-1:0] green,
	input  logic [VAL_W-1:0] blue,
	input  logic [VAL_W-1:0] opacity,
	input  logic [CNT_W-1:0] color_count,
	input  logic [CNT_W-1:0] alpha_count,
	output logic [VAL_W-1:0] out_red,
	output logic [VAL_W-1:0] out_green,
	output logic [VAL_W-1:0] out_blue,
	output logic [VAL_W-1:0] out_alpha
);

	logic [4*VAL_W-1:0] cmem [MAX_MARKERS];
	logic [2*VAL_W-1:0] amem [MAX_MARKERS];

	logic [CNT_W-1:0]   c_n, a_n, c_n_m1, a_n_m1, scan_end;
	logic [IDX_W-1:0]   c_ra, c_rb, a_ra, a_rb, scan_nxt;
	logic [4*VAL_W-1:0] c_rda_q, c_rdb_q;
	logic [2*VAL_W-1:0] a_rda_q, a_rdb_q;
	logic [VAL_W-1:0]   t_q;

	logic [VAL_W-1:0]   c_pa, c_pb, a_pa, a_pb;
	logic [3*VAL_W-1:0] c_vala, c_valb;
	logic [VAL_W-1:0]   a_vala, a_valb;
	logic               c_hit, a_hit, c_at_end, a_at_end;

	logic               c_done_q, c_interp_q, a_done_q, a_interp_q;
	logic [3*VAL_W-1:0] c_va_q, c_vb_q;
	logic [VAL_W-1:0]   a_va_q, a_vb_q;
	logic [VAL_W-1:0]   c_span_q, c_d_q, a_span_q, a_d_q;

	logic [VAL_W-1:0]   red_res, green_res, blue_res, alpha_res;
	logic [VAL_W-1:0]   out_red_q, out_green_q, out_blue_q, out_alpha_q;

	assign c_n      = sat_count(color_count);
	assign a_n      = sat_count(alpha_count);
	assign c_n_m1   = c_n - CNT_W'(1);
	assign a_n_m1   = a_n - CNT_W'(1);
	assign scan_nxt = cmd.scan_idx + IDX_W'(1);
	assign scan_end = CNT_W'(cmd.scan_idx) + CNT_W'(2);

	assign c_ra = cmd.first_rd ? '0 : cmd.scan_idx;
	assign c_rb = cmd.first_rd ? c_n_m1[IDX_W-1:0] : scan_nxt;
	assign a_ra = cmd.first_rd ? '0 : cmd.scan_idx;
	assign a_rb = cmd.first_rd ? a_n_m1[IDX_W-1:0] : scan_nxt;

	always_ff @(posedge clk) begin
		if (cmd.wr_color) begin
			cmem[marker_index] <= {position, red, green, blue};
		end
		if (cmd.wr_alpha) begin
			amem[marker_index] <= {position, opacity};
		end
		c_rda_q <= cmem[c_ra];
		c_rdb_q <= cmem[c_rb];
		a_rda_q <= amem[a_ra];
		a_rdb_q <= amem[a_rb];
		if (cmd.capture) begin
			t_q <= position;
		end
	end

	assign c_pa   = c_rda_q[4*VAL_W-1:3*VAL_W];
	assign c_pb   = c_rdb_q[4*VAL_W-1:3*VAL_W];
	assign c_vala = c_rda_q[3*VAL_W-1:0];
	assign c_valb = c_rdb_q[3*VAL_W-1:0];
	assign a_pa   = a_rda_q[2*VAL_W-1:VAL_W];
	assign a_pb   = a_rdb_q[2*VAL_W-1:VAL_W];
	assign a_vala = a_rda_q[VAL_W-1:0];
	assign a_valb = a_rdb_q[VAL_W-1:0];

	assign c_hit    = (c_pa <= t_q) && (t_q <= c_pb);
	assign a_hit    = (a_pa <= t_q) && (t_q <= a_pb);
	assign c_at_end = scan_end >= c_n;
	assign a_at_end = scan_end >= a_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_done_q   <= 1'b0;
			c_interp_q <= 1'b0;
			a_done_q   <= 1'b0;
			a_interp_q <= 1'b0;
		end else begin
			if (cmd.first_chk) begin
				c_done_q   <= (c_n == '0) || (t_q <= c_pa) || (t_q >= c_pb);
				c_interp_q <= 1'b0;
				a_done_q   <= (a_n == '0) || (t_q <= a_pa) || (t_q >= a_pb);
				a_interp_q <= 1'b0;
			end else if (cmd.scan_chk) begin
				if (!c_done_q && (c_hit || c_at_end)) begin
					c_done_q   <= 1'b1;
					c_interp_q <= c_hit;
				end
				if (!a_done_q && (a_hit || a_at_end)) begin
					a_done_q   <= 1'b1;
					a_interp_q <= a_hit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.first_chk) begin
			c_va_q <= (t_q <= c_pa) ? c_vala : c_valb;
			a_va_q <= (t_q <= a_pa) ? a_vala : a_valb;
		end else if (cmd.scan_chk) begin
			if (!c_done_q && c_hit) begin
				c_va_q   <= c_vala;
				c_vb_q   <= c_valb;
				c_span_q <= c_pb - c_pa;
				c_d_q    <= t_q - c_pa;
			end
			if (!a_done_q && a_hit) begin
				a_va_q   <= a_vala;
				a_vb_q   <= a_valb;
				a_span_q <= a_pb - a_pa;
				a_d_q    <= t_q - a_pa;
			end
		end
	end

	assign sts.all_done = c_done_q && a_done_q;

	crip_lane u_red (
		.clk    (clk),
		.cmd    (cmd.lane),
		.va     (c_va_q[3*VAL_W-1:2*VAL_W]),
		.vb     (c_vb_q[3*VAL_W-1:2*VAL_W]),
		.span   (c_span_q),
		.delta  (c_d_q),
		.interp (c_interp_q),
		.result (red_res)
	);

	crip_lane u_green (
		.clk    (clk),
		.cmd    (cmd.lane),
		.va     (c_va_q[2*VAL_W-1:VAL_W]),
		.vb     (c_vb_q[2*VAL_W-1:VAL_W]),
		.span   (c_span_q),
		.delta  (c_d_q),
		.interp (c_interp_q),
		.result (green_res)
	);

	crip_lane u_blue (
		.clk    (clk),
		.cmd    (cmd.lane),
		.va     (c_va_q[VAL_W-1:0]),
		.vb     (c_vb_q[VAL_W-1:0]),
		.span   (c_span_q),
		.delta  (c_d_q),
		.interp (c_interp_q),
		.result (blue_res)
	);

	crip_lane u_alpha (
		.clk    (clk),
		.cmd    (cmd.lane),
		.va     (a_va_q),
		.vb     (a_vb_q),
		.span   (a_span_q),
		.delta  (a_d_q),
		.interp (a_interp_q),
		.result (alpha_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_red_q   <= (c_n == '0) ? '0 : red_res;
			out_green_q <= (c_n == '0) ? '0 : green_res;
			out_blue_q  <= (c_n == '0) ? '0 : blue_res;
			out_alpha_q <= (a_n == '0) ? '1 : alpha_res;
		end
	end

	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign out_alpha = out_alpha_q;

endmodule

// ----- rtl/crip_ctrl.sv -----
// Controller state machine: handshakes, segment scan sequencing and divider steps.
`timescale 1ns / 1ps
module crip_ctrl import crip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	output logic       out_valid,
	input  logic       out_stall,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              in_take;
	logic              slot_free;

	assign in_take   = (state_q == S_IDLE) && in_valid;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take && (func == FUNC_SAMPLE)) begin
					state_d = S_FIRST_RD;
				end
			end
			S_FIRST_RD:  state_d = S_FIRST_CHK;
			S_FIRST_CHK: state_d = S_SCAN_RD;
			S_SCAN_RD:   state_d = sts.all_done ? S_MUL : S_SCAN_CHK;
			S_SCAN_CHK:  state_d = S_SCAN_RD;
			S_MUL:       state_d = S_LOAD;
			S_LOAD:      state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.scan_idx = idx_q;
		in_stall     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall     = 1'b0;
				cmd.wr_color = in_take && (func == FUNC_WR_COLOR);
				cmd.wr_alpha = in_take && (func == FUNC_WR_ALPHA);
				cmd.capture  = in_take && (func == FUNC_SAMPLE);
			end
			S_FIRST_RD:  cmd.first_rd = 1'b1;
			S_FIRST_CHK: cmd.first_chk = 1'b1;
			S_SCAN_RD:   cmd.first_rd = 1'b0;
			S_SCAN_CHK:  cmd.scan_chk = 1'b1;
			S_MUL:       cmd.lane.mul = 1'b1;
			S_LOAD:      cmd.lane.load = 1'b1;
			S_DIV:       cmd.lane.step = 1'b1;
			S_FINISH:    cmd.res_load = slot_free;
			default:     in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIRST_CHK) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN_CHK) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == S_LOAD) begin
				step_q <= '0;
			end else if (state_q == S_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/color_ramp_interpolator.sv -----
// A sample runs a segment scan of k steps, k from 0 to 7 (bounded by the larger marker
// count less one), and then 16 divider steps before its result is valid.
// The input stalls while a sample is in progress; marker writes are taken one per cycle otherwise.
// The result register lets the next transaction enter while a result waits to be taken.
// Reset clears both marker counts and all control state; marker tables hold
// undefined data until written.
`timescale 1ns / 1ps
module color_ramp_interpolator import crip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [IDX_W-1:0]  marker_index,
	input  logic [VAL_W-1:0]  position,
	input  logic [VAL_W-1:0]  red,
	input  logic [VAL_W-1:0]  green,
	input  logic [VAL_W-1:0]  blue,
	input  logic [VAL_W-1:0]  opacity,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  out_red,
	output logic [VAL_W-1:0]  out_green,
	output logic [VAL_W-1:0]  out_blue,
	output logic [VAL_W-1:0]  out_alpha
);

	logic [CNT_W-1:0] color_count_q;
	logic [CNT_W-1:0] alpha_count_q;
	logic             cfg_wr;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= '0;
			alpha_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COLOR_COUNT: color_count_q <= pwdata[CNT_W-1:0];
				REG_ALPHA_COUNT: alpha_count_q <= pwdata[CNT_W-1:0];
				default:         color_count_q <= color_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COLOR_COUNT: prdata = DATA_W'(color_count_q);
			REG_ALPHA_COUNT: prdata = DATA_W'(alpha_count_q);
			default:         prdata = '0;
		endcase
	end

	crip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	crip_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.marker_index (marker_index),
		.position     (position),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.opacity      (opacity),
		.color_count  (color_count_q),
		.alpha_count  (alpha_count_q),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha)
	);

`ifndef NO_ASSERTIONS
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == FUNC_SAMPLE) |=> in_stall)
		else $error("sample transaction did not occupy the block");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func != FUNC_SAMPLE) |=> !in_stall)
		else $error("marker write stalled the input");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a sample in progress");
`endif

endmodule

// ----- dv/tb_color_ramp_interpolator.sv -----
// Testbench for the color ramp interpolator: directed and random marker writes and samples.
`timescale 1ns / 1ps
module tb_color_ramp_interpolator;
	import crip_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]       code;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] pos;
		logic [VAL_W-1:0] red;
		logic [VAL_W-1:0] green;
		logic [VAL_W-1:0] blue;
		logic [VAL_W-1:0] opacity;
	} ramp_op_t;

	typedef struct packed {
		logic [VAL_W-1:0] red;
		logic [VAL_W-1:0] green;
		logic [VAL_W-1:0] blue;
		logic [VAL_W-1:0] alpha;
	} ramp_rgba_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [IDX_W-1:0]  marker_index;
	logic [VAL_W-1:0]  position;
	logic [VAL_W-1:0]  red;
	logic [VAL_W-1:0]  green;
	logic [VAL_W-1:0]  blue;
	logic [VAL_W-1:0]  opacity;
	logic              out_valid;
	logic              out_stall;
	logic [VAL_W-1:0]  out_red;
	logic [VAL_W-1:0]  out_green;
	logic [VAL_W-1:0]  out_blue;
	logic [VAL_W-1:0]  out_alpha;

	color_ramp_interpolator dut (.*);

	ramp_op_t   ramp_ops_pending[$];
	ramp_rgba_t samples_due[$];
	ramp_op_t   op_on_bus;
	int         ops_open;
	int         failures;
	int         in_gap;
	int         out_gap;
	int         in_idle_pct;
	int         out_idle_pct;
	bit         in_took;

	logic [CNT_W-1:0] color_count;
	logic [CNT_W-1:0] alpha_count;
	logic [MAX_MARKERS-1:0][VAL_W-1:0] color_pos, color_red, color_green, color_blue;
	logic [MAX_MARKERS-1:0][VAL_W-1:0] alpha_pos, alpha_val;
	logic [MAX_MARKERS-1:0][VAL_W-1:0] gen_color_pos, gen_alpha_pos;

	function automatic void locate_segment(input logic [MAX_MARKERS-1:0][VAL_W-1:0] pos,
			input int n, input logic [VAL_W-1:0] t, output int lo, output bit interp);
		int i;
		lo = n - 1;
		interp = 1'b0;
		if (t <= pos[0]) begin
			lo = 0;
		end else if (t < pos[n-1]) begin
			for (i = 0; i + 1 < n; i++) begin
				if (t >= pos[i] && t <= pos[i+1]) begin
					lo = i;
					interp = 1'b1;
					break;
				end
			end
		end
	endfunction

	function automatic logic [VAL_W-1:0] blend_channel(input logic [VAL_W-1:0] va, vb,
			input logic [VAL_W-1:0] lo_pos, hi_pos, t);
		logic [63:0] span, d, num;
		span = 64'(hi_pos) - 64'(lo_pos);
		d = 64'(t) - 64'(lo_pos);
		if (span == 0)
			return va;
		num = 64'(va) * (span - d) + 64'(vb) * d;
		return VAL_W'(num / span);
	endfunction

	function automatic ramp_rgba_t sample_ramp(input logic [VAL_W-1:0] t);
		ramp_rgba_t res;
		int n, lo;
		bit interp;
		n = (color_count > MAX_MARKERS) ? MAX_MARKERS : int'(color_count);
		if (n == 0) begin
			res.red = '0;
			res.green = '0;
			res.blue = '0;
		end else begin
			locate_segment(color_pos, n, t, lo, interp);
			if (interp) begin
				res.red = blend_channel(color_red[lo], color_red[lo+1], color_pos[lo],
					color_pos[lo+1], t);
				res.green = blend_channel(color_green[lo], color_green[lo+1], color_pos[lo],
					color_pos[lo+1], t);
				res.blue = blend_channel(color_blue[lo], color_blue[lo+1], color_pos[lo],
					color_pos[lo+1], t);
			end else begin
				res.red = color_red[lo];
				res.green = color_green[lo];
				res.blue = color_blue[lo];
			end
		end
		n = (alpha_count > MAX_MARKERS) ? MAX_MARKERS : int'(alpha_count);
		if (n == 0) begin
			res.alpha = '1;
		end else begin
			locate_segment(alpha_pos, n, t, lo, interp);
			if (interp)
				res.alpha = blend_channel(alpha_val[lo], alpha_val[lo+1], alpha_pos[lo],
					alpha_pos[lo+1], t);
			else
				res.alpha = alpha_val[lo];
		end
		return res;
	endfunction

	task automatic apply_op(input ramp_op_t op);
		case (op.code)
			FUNC_WR_COLOR: begin
				color_pos[op.idx] = op.pos;
				color_red[op.idx] = op.red;
				color_green[op.idx] = op.green;
				color_blue[op.idx] = op.blue;
			end
			FUNC_WR_ALPHA: begin
				alpha_pos[op.idx] = op.pos;
				alpha_val[op.idx] = op.opacity;
			end
			FUNC_SAMPLE: begin
				samples_due.push_back(sample_ramp(op.pos));
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [VAL_W-1:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			failures++;
		end
	endtask

	task automatic queue_op(input logic [1:0] code, input int idx, input logic [VAL_W-1:0] pos,
			input logic [VAL_W-1:0] r, g, b, o);
		ramp_op_t op;
		op.code = code;
		op.idx = IDX_W'(idx);
		op.pos = pos;
		op.red = r;
		op.green = g;
		op.blue = b;
		op.opacity = o;
		if (code == FUNC_WR_COLOR)
			gen_color_pos[op.idx] = pos;
		else if (code == FUNC_WR_ALPHA)
			gen_alpha_pos[op.idx] = pos;
		ops_open++;
		ramp_ops_pending.push_back(op);
	endtask

	task automatic queue_sample(input logic [VAL_W-1:0] t);
		queue_op(FUNC_SAMPLE, $urandom_range(0, MAX_MARKERS - 1), t, VAL_W'($urandom),
			VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
	endtask

	task automatic drain;
		while (ops_open != 0 || samples_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic reg_sel, input logic [CNT_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CNT_W-1:0] !== value) begin
			$display("%0t: register %0d readback mismatch: expected %h, got %h", $time,
				reg_sel, value, prdata[CNT_W-1:0]);
			failures++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == REG_COLOR_COUNT)
			color_count = value;
		else
			alpha_count = value;
	endtask

	task automatic fill_track(input logic [1:0] code, input int n);
		int i;
		logic [VAL_W-1:0] p;
		p = VAL_W'($urandom_range(0, 4000));
		for (i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 7) != 0)
				p = p + VAL_W'($urandom_range(0, (65535 - int'(p)) / (n - i)));
			queue_op(code, i, p, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
				VAL_W'($urandom));
		end
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] cc, ac, input int in_pct, out_pct,
			input int n_ops);
		int nc, na, made, roll, t;
		drain();
		write_count(REG_COLOR_COUNT, cc);
		write_count(REG_ALPHA_COUNT, ac);
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		nc = (cc > MAX_MARKERS) ? MAX_MARKERS : int'(cc);
		na = (ac > MAX_MARKERS) ? MAX_MARKERS : int'(ac);
		fill_track(FUNC_WR_COLOR, nc);
		fill_track(FUNC_WR_ALPHA, na);
		made = nc + na;
		while (made < n_ops) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				fill_track(FUNC_WR_COLOR, nc);
				fill_track(FUNC_WR_ALPHA, na);
				made += nc + na;
			end else if (roll < 30) begin
				queue_op(roll < 18 ? FUNC_WR_COLOR : FUNC_WR_ALPHA,
					$urandom_range(0, MAX_MARKERS - 1), VAL_W'($urandom), VAL_W'($urandom),
					VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
				made++;
			end else if (roll < 33) begin
				queue_op(FUNC_UNUSED, $urandom_range(0, MAX_MARKERS - 1), VAL_W'($urandom),
					VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
			end else begin
				case ($urandom_range(0, 7))
					0: t = 0;
					1: t = 65535;
					2: t = int'(gen_color_pos[$urandom_range(0, MAX_MARKERS - 1)])
						+ int'($urandom_range(0, 4)) - 2;
					3: t = int'(gen_alpha_pos[$urandom_range(0, MAX_MARKERS - 1)])
						+ int'($urandom_range(0, 4)) - 2;
					default: t = int'($urandom_range(0, 65535));
				endcase
				if (t < 0)
					t = 0;
				if (t > 65535)
					t = 65535;
				queue_sample(VAL_W'(t));
				made++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			in_took = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (ramp_ops_pending.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
				in_gap = $urandom_range(0, 10);
				in_valid <= 1'b0;
			end else if (ramp_ops_pending.size() != 0) begin
				op_on_bus = ramp_ops_pending.pop_front();
				in_valid <= 1'b1;
				func <= op_on_bus.code;
				marker_index <= op_on_bus.idx;
				position <= op_on_bus.pos;
				red <= op_on_bus.red;
				green <= op_on_bus.green;
				blue <= op_on_bus.blue;
				opacity <= op_on_bus.opacity;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < out_idle_pct) begin
			out_gap = $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		ramp_rgba_t want;
		if (arst_n && in_valid && !in_stall) begin
			in_took = 1'b1;
			ops_open--;
			apply_op(op_on_bus);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (samples_due.size() == 0) begin
				$display("%0t: result with no sample pending: expected none, got %h %h %h %h",
					$time, out_red, out_green, out_blue, out_alpha);
				failures++;
			end else begin
				want = samples_due.pop_front();
				check_field("out_red", want.red, out_red);
				check_field("out_green", want.green, out_green);
				check_field("out_blue", want.blue, out_blue);
				check_field("out_alpha", want.alpha, out_alpha);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		func = FUNC_WR_COLOR;
		marker_index = '0;
		position = '0;
		red = '0;
		green = '0;
		blue = '0;
		opacity = '0;
		ops_open = 0;
		failures = 0;
		in_gap = 0;
		out_gap = 0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		in_took = 1'b0;
		color_count = '0;
		alpha_count = '0;
		color_pos = '0;
		color_red = '0;
		color_green = '0;
		color_blue = '0;
		alpha_pos = '0;
		alpha_val = '0;
		gen_color_pos = '0;
		gen_alpha_pos = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty tracks straight after reset
		queue_sample(16'h0000);
		queue_sample(16'hffff);
		drain();
		write_count(REG_COLOR_COUNT, 4'd4);
		write_count(REG_ALPHA_COUNT, 4'd3);
		in_idle_pct = 25;
		out_idle_pct = 25;
		queue_op(FUNC_UNUSED, 7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		queue_op(FUNC_WR_COLOR, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_op(FUNC_WR_COLOR, 1, 16'h4000, 16'hffff, 16'h0000, 16'h1234, 16'h0000);
		queue_op(FUNC_WR_COLOR, 2, 16'h4000, 16'h0000, 16'hffff, 16'hffff, 16'hffff);
		queue_op(FUNC_WR_COLOR, 3, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
		queue_op(FUNC_WR_ALPHA, 0, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
		queue_op(FUNC_WR_ALPHA, 1, 16'h9000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_op(FUNC_WR_ALPHA, 2, 16'hf000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
		queue_sample(16'h0000);
		queue_sample(16'h0800);
		queue_sample(16'h2000);
		queue_sample(16'h4000);
		queue_sample(16'h9000);
		queue_sample(16'hf800);
		queue_sample(16'hffff);
		// break the ascending order of the color track
		queue_op(FUNC_WR_COLOR, 1, 16'hc000, 16'h8000, 16'h0001, 16'hfffe, 16'h0000);
		queue_sample(16'ha000);
		queue_sample(16'hd000);

		run_phase(4'd0, 4'd0, 10, 30, 170);
		run_phase(4'd8, 4'd8, 30, 10, 170);
		run_phase(4'd1, 4'd8, 0, 0, 170);
		run_phase(4'd15, 4'd0, 20, 20, 170);
		run_phase(4'd2, 4'd2, 10, 40, 170);
		run_phase(4'd8, 4'd1, 40, 10, 170);
		run_phase(CNT_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 15)), 15, 15, 170);
		run_phase(CNT_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 15)), 0, 25, 170);
		run_phase(CNT_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 15)), 25, 0, 170);
		run_phase(4'd8, 4'd12, 0, 0, 170);
		drain();

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
